>>> hdl/rtp_pkg.sv
// rtp_pkg: shared types, command codes and defaults of the ring transmit packetizer
// no dependencies; used by the top level and the testbench
`timescale 1ns / 1ps

package rtp_pkg;

  // default parameter values
  localparam int RING_SIZE_DEF = 2048;
  localparam int NUM_PORTS_DEF = 2;

  // packet size register
  localparam int          MPS_W     = 10;
  localparam logic [9:0]  MPS_RESET = 10'd64;
  localparam logic [9:0]  MPS_MAX   = 10'd512;

  // command codes of an input beat
  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_SOF       = 2'd1,
    CMD_XFER_DONE = 2'd2
  } cmd_t;

  typedef logic [MPS_W-1:0] mps_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        port;
    logic [10:0] load_length;
    logic        configured;
  } in_beat_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_offset;
    logic [9:0]  tx_length;
    logic [10:0] accepted_length;
    logic        busy_res;
  } out_beat_t;

endpackage

>>> hdl/rtp_chan_if.sv
// rtp_chan_if: valid/ready channel carrying one payload of type T
// depends on nothing; payload types come from rtp_pkg at instantiation
`timescale 1ns / 1ps

interface rtp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ring_tx_packetizer.sv
// ring_tx_packetizer: per-port bulk IN transmit scheduler over a ring buffer
// depends on rtp_pkg and rtp_chan_if
`timescale 1ns / 1ps

//  channel    dir  payload      beat
//  cfg_chan   in   mps_t        write of max_packet_size
//  in_chan    in   in_beat_t    one event (load, start of frame, transfer complete)
//  out_chan   out  out_beat_t   one result per event
//
//  every event is evaluated against the port state as it is accepted, and state
//  and result register are loaded at the same edge
//  a new event is taken each cycle while the result register is empty or drained
//  an unread result stalls in_chan only; cfg_chan is always ready
//  rst_n is synchronous, active low: all ports idle, packet size back to 64

module ring_tx_packetizer
  import rtp_pkg::*;
#(
  parameter int RING_SIZE = RING_SIZE_DEF,
  parameter int NUM_PORTS = NUM_PORTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rtp_chan_if.sink   cfg_chan,
  rtp_chan_if.sink   in_chan,
  rtp_chan_if.source out_chan
);

  // position width: holds 0 .. RING_SIZE
  localparam int PW = $clog2(RING_SIZE + 1);
  // compare widths for the load length and the packet limit
  localparam int CW = (PW > 11) ? PW : 11;
  localparam int MW = (PW > 10) ? PW : 10;

  // packet size register
  mps_t mps_r;
  logic [9:0] lim;

  // per-port state
  logic          busy_r [NUM_PORTS];
  logic [PW-1:0] rp_r   [NUM_PORTS];
  logic [PW-1:0] we_r   [NUM_PORTS];
  logic [PW-1:0] rem_r  [NUM_PORTS];

  // selected port, current state
  logic [NUM_PORTS-1:0] hit;
  logic          port_ok;
  logic          cur_busy;
  logic [PW-1:0] cur_rp, cur_we, cur_rem;

  // next state of the selected port
  logic          busy_nxt;
  logic [PW-1:0] rp_nxt, we_nxt, rem_nxt;

  // working values
  logic          iss;
  logic [PW-1:0] base_rp, base_rem, rp_wrap, span;
  logic [CW-1:0] len_ext, len_sat;
  logic [MW-1:0] rem_m, lim_m;
  logic [9:0]    chunk;
  logic [CW-1:0] off_ext;

  out_beat_t res;
  logic      accept;

  // result register
  logic      out_valid_r;
  out_beat_t out_data_r;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign accept         = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // zero acts as one, anything above 512 as 512
  always_comb begin
    if (mps_r == '0) begin
      lim = 10'd1;
    end else if (mps_r > MPS_MAX) begin
      lim = MPS_MAX;
    end else begin
      lim = mps_r;
    end
  end

  // select the addressed port's state
  always_comb begin
    cur_busy = 1'b0;
    cur_rp   = '0;
    cur_we   = '0;
    cur_rem  = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      hit[p]   = (int'(in_chan.data.port) == p);
      cur_busy = cur_busy | (hit[p] & busy_r[p]);
      cur_rp   = cur_rp   | ({PW{hit[p]}} & rp_r[p]);
      cur_we   = cur_we   | ({PW{hit[p]}} & we_r[p]);
      cur_rem  = cur_rem  | ({PW{hit[p]}} & rem_r[p]);
    end
    port_ok = |hit;
  end

  // load length saturates just below the ring size
  assign len_ext = CW'(in_chan.data.load_length);
  assign len_sat = (len_ext >= CW'(RING_SIZE)) ? CW'(RING_SIZE - 1) : len_ext;

  // start of frame: wrap a read position at the ring end, span to write end or ring end
  assign rp_wrap = (cur_rp >= PW'(RING_SIZE)) ? '0 : cur_rp;
  assign span    = (rp_wrap > cur_we) ? (PW'(RING_SIZE) - rp_wrap) : (cur_we - rp_wrap);

  // event evaluation
  always_comb begin
    busy_nxt = cur_busy;
    rp_nxt   = cur_rp;
    we_nxt   = cur_we;
    rem_nxt  = cur_rem;
    base_rp  = cur_rp;
    base_rem = cur_rem;
    iss      = 1'b0;
    res      = '0;

    if (port_ok) begin
      case (in_chan.data.cmd)
        CMD_LOAD: begin
          if (!cur_busy) begin
            rem_nxt             = '0;
            we_nxt              = PW'(len_sat);
            rp_nxt              = '0;
            res.accepted_length = len_sat[10:0];
          end
        end
        CMD_SOF: begin
          if (in_chan.data.configured && !cur_busy) begin
            rp_nxt  = rp_wrap;
            base_rp = rp_wrap;
            if (rp_wrap != cur_we) begin
              base_rem = span;
              iss      = 1'b1;
              busy_nxt = 1'b1;
            end
          end
        end
        CMD_XFER_DONE: begin
          if (cur_busy) begin
            if (cur_rem == '0) begin
              busy_nxt = 1'b0;
            end else begin
              iss = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // next chunk: min of residual span and packet limit
    rem_m   = MW'(base_rem);
    lim_m   = MW'(lim);
    chunk   = (rem_m > lim_m) ? lim_m[9:0] : rem_m[9:0];
    off_ext = CW'(base_rp);

    if (iss) begin
      res.tx_valid  = 1'b1;
      res.tx_offset = off_ext[10:0];
      res.tx_length = chunk;
      rp_nxt        = base_rp + PW'(chunk);
      rem_nxt       = base_rem - PW'(chunk);
    end

    res.busy_res = port_ok & busy_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mps_r <= MPS_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      mps_r <= cfg_chan.data;
    end
  end

  // port state write-back
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (!rst_n) begin
        busy_r[p] <= 1'b0;
        rp_r[p]   <= '0;
        we_r[p]   <= '0;
        rem_r[p]  <= '0;
      end else if (accept && hit[p]) begin
        busy_r[p] <= busy_nxt;
        rp_r[p]   <= rp_nxt;
        we_r[p]   <= we_nxt;
        rem_r[p]  <= rem_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  // an issued packet is never empty and never above the packet limit
  a_len_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tx_valid |->
      (out_data_r.tx_length != '0) && (out_data_r.tx_length <= lim))
    else $error("issued packet length outside 1..limit");

  // issuing a packet leaves the port busy
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tx_valid |-> out_data_r.busy_res)
    else $error("packet issued on an idle port");

  // a load never issues a packet in the same event
  a_load_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.accepted_length != '0) |-> !out_data_r.tx_valid)
    else $error("load result carries a packet");

  // an idle port has no residual span
  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_idle_chk
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
      !busy_r[g] |-> (rem_r[g] == '0))
      else $error("idle port with residual span");
  end

endmodule

>>> test/ring_tx_packetizer_tb.sv
// ring_tx_packetizer_tb: self-checking bench for the ring transmit packetizer
// depends on rtp_pkg, rtp_chan_if and ring_tx_packetizer; an in-bench scheduler
// model predicts every result beat and the monitor compares it field by field
`timescale 1ns / 1ps

module ring_tx_packetizer_tb;
  import rtp_pkg::*;

  localparam int RING = RING_SIZE_DEF;
  localparam int NPORT = NUM_PORTS_DEF;
  // cmd value the block leaves unused, still driven as noise
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int GAP_PCT = 22;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_EVENTS = 195;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rtp_chan_if #(.T(mps_t))      cfg_if ();
  rtp_chan_if #(.T(in_beat_t))  in_if ();
  rtp_chan_if #(.T(out_beat_t)) out_if ();

  ring_tx_packetizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_if),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #10 clk = ~clk;

  // scheduler model: per-port busy flag, read position, write end, residue
  logic        port_busy [NPORT];
  logic [11:0] rd_pos    [NPORT];
  logic [11:0] wr_end    [NPORT];
  logic [11:0] residue   [NPORT];
  mps_t        mps_shadow;

  in_beat_t  events_to_send [$];   // events waiting for the driver
  out_beat_t owed_results [$];     // predicted result beats, oldest first

  int  n_pushed = 0;      // events handed to the driver
  int  n_accepted = 0;    // input beats taken by the block
  int  n_results = 0;     // result beats seen
  int  n_packets = 0;     // result beats that issued a packet
  int  n_settings = 1;    // packet-size settings exercised
  int  n_errors = 0;
  int  send_gap_pct = GAP_PCT;
  int  take_gap_pct = GAP_PCT;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  bit  in_fired = 1'b0;
  bit  cfg_fired = 1'b0;

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // issue the next chunk of the residual span, capped by the packet size
  function automatic out_beat_t send_chunk(input int p, input out_beat_t r);
    logic [11:0] lim;
    logic [11:0] n;
    if (mps_shadow == '0) lim = 12'd1;
    else if (mps_shadow > MPS_MAX) lim = {2'b00, MPS_MAX};
    else lim = {2'b00, mps_shadow};
    n = (residue[p] > lim) ? lim : residue[p];
    r.tx_valid  = 1'b1;
    r.tx_offset = rd_pos[p][10:0];
    r.tx_length = n[9:0];
    rd_pos[p]  += n;
    residue[p] -= n;
    return r;
  endfunction

  // apply one event to the model and return the result beat it owes
  function automatic out_beat_t sched_event(input in_beat_t ev);
    out_beat_t   r;
    int          p;
    logic [11:0] len;
    r = '0;
    p = int'(ev.port);
    if (p >= NPORT) return r;
    case (ev.cmd)
      CMD_LOAD: begin
        // loads only land on an idle port; oversize saturates at the ring end
        if (!port_busy[p]) begin
          len = {1'b0, ev.load_length};
          if (len > 12'(RING - 1)) len = 12'(RING - 1);
          residue[p] = '0;
          wr_end[p]  = len;
          rd_pos[p]  = '0;
          r.accepted_length = len[10:0];
        end
      end
      CMD_SOF: begin
        if (ev.configured && !port_busy[p]) begin
          if (rd_pos[p] >= 12'(RING)) rd_pos[p] = '0;
          // empty span leaves the port idle with no packet
          if (rd_pos[p] != wr_end[p]) begin
            if (rd_pos[p] > wr_end[p]) residue[p] = 12'(RING) - rd_pos[p];
            else residue[p] = wr_end[p] - rd_pos[p];
            r = send_chunk(p, r);
            port_busy[p] = 1'b1;
          end
        end
      end
      CMD_XFER_DONE: begin
        if (port_busy[p]) begin
          if (residue[p] == '0) port_busy[p] = 1'b0;
          else r = send_chunk(p, r);
        end
      end
      default: ;
    endcase
    r.busy_res = port_busy[p];
    return r;
  endfunction

  function automatic in_beat_t make_event(input logic [1:0] c, input int p, input int len,
                                          input bit cfgd);
    in_beat_t e;
    e.cmd = c;
    e.port = p[0];
    e.load_length = len[10:0];
    e.configured = cfgd;
    return e;
  endfunction

  function automatic in_beat_t random_event();
    return make_event(2'($urandom_range(0, 3)), $urandom_range(0, NPORT - 1),
                      $urandom_range(0, RING - 1), 1'($urandom_range(0, 1)));
  endfunction

  task automatic post(input in_beat_t e);
    events_to_send.push_back(e);
    n_pushed++;
  endtask

  // block is idle once every posted event is taken and answered
  task automatic wait_all_results();
    while (n_accepted != n_pushed || owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_mps(input mps_t v);
    @(negedge clk);
    cfg_if.data  <= v;
    cfg_if.valid <= 1'b1;
    do @(negedge clk); while (!cfg_fired);
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // one phase of random traffic: two interleaved load / sof / completion
  // transfers per burst, sprinkled with noise and sometimes cut short
  task automatic queue_phase(input int lim, input int count);
    in_beat_t s0 [$];
    in_beat_t s1 [$];
    in_beat_t e;
    int base, len, max_len, n, k, p, roll;
    base = n_pushed;
    while (n_pushed - base < count) begin
      for (p = 0; p < NPORT; p++) begin
        max_len = (lim >= 256) ? RING - 1 : lim * 6;
        roll = $urandom_range(0, 99);
        if (roll < 10) len = max_len;
        else if (roll < 15) len = 0;
        else len = $urandom_range(0, max_len);
        n = (len + lim - 1) / lim + 1;
        // a broken sequence leaves the port busy into the next burst
        if ($urandom_range(0, 99) < 10) n = $urandom_range(0, n);
        for (k = 0; k < n + 2; k++) begin
          if (k == 0) e = make_event(CMD_LOAD, p, len, 1'b1);
          else if (k == 1) e = make_event(CMD_SOF, p, $urandom_range(0, RING - 1), 1'b1);
          else e = make_event(CMD_XFER_DONE, p, $urandom_range(0, RING - 1),
                              1'($urandom_range(0, 1)));
          if (p == 0) s0.push_back(e);
          else s1.push_back(e);
        end
      end
      while (s0.size() != 0 || s1.size() != 0) begin
        if ($urandom_range(0, 99) < 15) post(random_event());
        if (s0.size() != 0 && (s1.size() == 0 || $urandom_range(0, 1) == 1))
          post(s0.pop_front());
        else
          post(s1.pop_front());
      end
    end
  endtask

  // sample handshakes at the rising edge: update the model, check results
  always @(posedge clk) begin : sample
    out_beat_t got;
    out_beat_t want;
    in_fired  = rst_n && in_if.valid && in_if.ready;
    cfg_fired = rst_n && cfg_if.valid && cfg_if.ready;
    // model resets along with the block
    if (!rst_n) begin
      mps_shadow = MPS_RESET;
      for (int p = 0; p < NPORT; p++) begin
        port_busy[p] = 1'b0;
        rd_pos[p]    = '0;
        wr_end[p]    = '0;
        residue[p]   = '0;
      end
    end
    // an event sees the packet size from before a write at the same edge
    if (in_fired) begin
      owed_results.push_back(sched_event(in_if.data));
      n_accepted++;
    end
    if (cfg_fired) mps_shadow = cfg_if.data;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (owed_results.size() == 0) begin
        report_error($sformatf("result beat %0d with no event awaiting it", n_results));
      end else begin
        want = owed_results.pop_front();
        if (want.tx_valid) n_packets++;
        if (got.tx_valid !== want.tx_valid)
          report_error($sformatf("beat %0d: tx_valid %0b, want %0b",
                                 n_results, got.tx_valid, want.tx_valid));
        if (got.tx_offset !== want.tx_offset)
          report_error($sformatf("beat %0d: tx_offset %0d, want %0d",
                                 n_results, got.tx_offset, want.tx_offset));
        if (got.tx_length !== want.tx_length)
          report_error($sformatf("beat %0d: tx_length %0d, want %0d",
                                 n_results, got.tx_length, want.tx_length));
        if (got.accepted_length !== want.accepted_length)
          report_error($sformatf("beat %0d: accepted_length %0d, want %0d",
                                 n_results, got.accepted_length, want.accepted_length));
        if (got.busy_res !== want.busy_res)
          report_error($sformatf("beat %0d: busy_res %0b, want %0b",
                                 n_results, got.busy_res, want.busy_res));
      end
      n_results++;
    end
  end

  // event driver: holds a beat until taken, then offers the next or a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fired) begin
      if (events_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_if.data  <= events_to_send.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink: random back-pressure plus an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= take_gap_pct);
      end
    end
  end

  // watchdog, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("ring_tx_packetizer_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    mps_t mps_plan [0:6];
    int   ph, lim, base;

    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle completion, empty span, full-ring load, unconfigured
    // frame, load and frame while busy, spare command, zero-length load,
    // short transfer run to idle, completion after idle
    post(make_event(CMD_XFER_DONE, 0, 0, 1'b0));
    post(make_event(CMD_SOF, 0, 0, 1'b1));
    post(make_event(CMD_LOAD, 0, RING - 1, 1'b1));
    post(make_event(CMD_SOF, 0, 0, 1'b0));
    post(make_event(CMD_SOF, 0, 0, 1'b1));
    post(make_event(CMD_LOAD, 0, 5, 1'b0));
    post(make_event(CMD_SOF, 0, RING - 1, 1'b1));
    post(make_event(CMD_SPARE, 0, RING - 1, 1'b1));
    post(make_event(CMD_SPARE, 1, 0, 1'b0));
    post(make_event(CMD_LOAD, 1, 0, 1'b0));
    post(make_event(CMD_SOF, 1, 0, 1'b1));
    post(make_event(CMD_LOAD, 1, 100, 1'b1));
    post(make_event(CMD_SOF, 1, 0, 1'b1));
    post(make_event(CMD_XFER_DONE, 1, 0, 1'b1));
    post(make_event(CMD_XFER_DONE, 1, RING - 1, 1'b0));
    post(make_event(CMD_XFER_DONE, 1, 0, 1'b1));
    post(make_event(CMD_LOAD, 1, 1, 1'b1));
    post(make_event(CMD_SOF, 1, 0, 1'b1));
    post(make_event(CMD_XFER_DONE, 1, 0, 1'b1));
    post(make_event(CMD_XFER_DONE, 1, 0, 1'b1));
    post(make_event(CMD_XFER_DONE, 0, 0, 1'b1));
    wait_all_results();

    // random traffic at the reset packet size
    queue_phase(64, PHASE_EVENTS);
    wait_all_results();

    // packet sizes: smallest, largest, zero and above-range encodings,
    // one random legal value, then back to the reset value
    mps_plan[0] = 10'd1;
    mps_plan[1] = MPS_MAX;
    mps_plan[2] = 10'd0;
    mps_plan[3] = 10'd1023;
    mps_plan[4] = 10'd513;
    mps_plan[5] = mps_t'($urandom_range(2, 511));
    mps_plan[6] = MPS_RESET;

    for (ph = 0; ph < 7; ph++) begin
      write_mps(mps_plan[ph]);
      if (mps_plan[ph] == '0) lim = 1;
      else if (mps_plan[ph] > MPS_MAX) lim = int'(MPS_MAX);
      else lim = int'(mps_plan[ph]);
      // one stretch runs both sides flat out
      if (ph == 4) begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end
      base = n_pushed;
      queue_phase(lim, PHASE_EVENTS);
      // long sink stall while the driver keeps offering: input must back up
      if (ph == 1) begin
        while (n_accepted < base + 30) @(negedge clk);
        hold_req = 1'b1;
      end
      wait_all_results();
      send_gap_pct = GAP_PCT;
      take_gap_pct = GAP_PCT;
    end

    // let any stray result beat surface before closing
    repeat (4) @(negedge clk);
    $display("covered %0d events and %0d result beats (%0d packets) over %0d packet sizes,",
             n_accepted, n_results, n_packets, n_settings);
    $display("including a long output stall and an unthrottled stretch");
    if (n_errors == 0) begin
      $display("ring_tx_packetizer_tb: done, clean");
    end else begin
      $display("ring_tx_packetizer_tb: done, errors");
    end
    $finish;
  end

endmodule
